// ===== src/text_console_glyph_renderer_defines.svh =====
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TCGR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TCGR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tcgr_pkg.sv =====
`default_nettype none

package tcgr_pkg;

    localparam int COLUMNS      = 88;
    localparam int ROWS         = 30;
    localparam int LINE_PITCH   = 800;
    localparam int CELL_WIDTH   = 9;
    localparam int GLYPH_HEIGHT = 16;

    localparam int ADDR_W     = 19;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int CODE_W     = 8;
    localparam int GROW_W     = 4;
    localparam int FONT_AW    = CODE_W + GROW_W;
    localparam int CNT_W      = $clog2(GLYPH_HEIGHT + 1);
    localparam int ROW_STRIDE = GLYPH_HEIGHT * LINE_PITCH;

    localparam int COL_DIV       = COLUMNS + 1;
    localparam int ROW_DIV       = ROWS + 1;
    localparam int COL_MOD_STEPS = 255 / COL_DIV;
    localparam int ROW_MOD_STEPS = 255 / ROW_DIV;

    localparam logic [CODE_W-1:0] CODE_TAB = 8'd9;
    localparam logic [CODE_W-1:0] CODE_NL  = 8'd10;
    localparam logic [CODE_W-1:0] CODE_CR  = 8'd13;

    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_SET  = 2'd1,
        OP_LOAD = 2'd2,
        OP_HOME = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DRAW = 1'b1
    } state_t;

    typedef struct packed {
        logic              en;
        op_t               op;
        logic [CODE_W-1:0] code;
        logic [7:0]        column;
        logic [7:0]        line;
    } cursor_req_t;

    typedef struct packed {
        logic              draw;
        logic [ADDR_W-1:0] base_addr;
    } cursor_stat_t;

    function automatic logic [COL_W-1:0] mod_col(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        for (int k = 0; k < COL_MOD_STEPS; k++) begin
            if (r >= 8'(COL_DIV)) begin
                r = r - 8'(COL_DIV);
            end
        end
        return r[COL_W-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] mod_row(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        for (int k = 0; k < ROW_MOD_STEPS; k++) begin
            if (r >= 8'(ROW_DIV)) begin
                r = r - 8'(ROW_DIV);
            end
        end
        return r[ROW_W-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] r);
        logic [ROW_W-1:0] n;
        n = r + ROW_W'(1);
        if (n >= ROW_W'(ROWS) || n == '0) begin
            n = ROW_W'(ROWS - 1);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== src/tcgr_font_store.sv =====
`default_nettype none

module tcgr_font_store (
    input  wire logic                        aclk,
    input  wire logic                        we,
    input  wire logic                        re,
    input  wire logic [tcgr_pkg::FONT_AW-1:0] addr,
    input  wire logic [7:0]                  wdata,
    output logic      [7:0]                  rdata
);

    logic [7:0] mem [2**tcgr_pkg::FONT_AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/tcgr_cursor.sv =====
`default_nettype none

module tcgr_cursor (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire tcgr_pkg::cursor_req_t  req,
    output tcgr_pkg::cursor_stat_t      stat
);

    logic [tcgr_pkg::COL_W-1:0] col_reg, col_next, col_inc;
    logic [tcgr_pkg::ROW_W-1:0] row_reg, row_next;
    logic                       is_ctrl;
    logic [31:0]                base_wide;

    assign is_ctrl = (req.code == tcgr_pkg::CODE_NL) || (req.code == tcgr_pkg::CODE_CR) ||
                     (req.code == tcgr_pkg::CODE_TAB);
    assign col_inc = col_reg + tcgr_pkg::COL_W'(1);

    assign base_wide = 32'(row_reg) * 32'(tcgr_pkg::ROW_STRIDE) +
                       32'(col_reg) * 32'(tcgr_pkg::CELL_WIDTH);
    assign stat.base_addr = base_wide[tcgr_pkg::ADDR_W-1:0];
    assign stat.draw      = req.en && (req.op == tcgr_pkg::OP_PUT) && !is_ctrl;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (req.en) begin
            unique case (req.op)
                tcgr_pkg::OP_PUT: begin
                    if (req.code == tcgr_pkg::CODE_NL) begin
                        col_next = '0;
                        row_next = tcgr_pkg::next_row(row_reg);
                    end else if (req.code == tcgr_pkg::CODE_CR) begin
                        col_next = '0;
                    end else if (req.code == tcgr_pkg::CODE_TAB) begin
                        col_next = {col_reg[tcgr_pkg::COL_W-1:3] + 4'd1, 3'd0};
                    end else if (col_inc >= tcgr_pkg::COL_W'(tcgr_pkg::COLUMNS) ||
                                 col_inc == '0) begin
                        col_next = '0;
                        row_next = tcgr_pkg::next_row(row_reg);
                    end else begin
                        col_next = col_inc;
                    end
                end
                tcgr_pkg::OP_SET: begin
                    col_next = tcgr_pkg::mod_col(req.column);
                    row_next = tcgr_pkg::mod_row(req.line);
                end
                tcgr_pkg::OP_LOAD: begin
                    col_next = col_reg;
                end
                tcgr_pkg::OP_HOME: begin
                    col_next = '0;
                    row_next = '0;
                end
                default: begin
                    col_next = col_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/text_console_glyph_renderer.sv =====
// Text console glyph renderer.
// Input stream (s_axis_*): one request per operation. tuser carries the
// operation (put character, set cursor, load font row, home cursor); tdata
// carries the operands. Output stream (m_axis_*): one framebuffer row write
// per glyph row, tlast marking the final row of a character.
// Set, home, font load and control codes (newline, carriage return, tab)
// produce no output. A printable character is accepted and starts the first
// font read, then gives one row per cycle while m_axis_tready is high,
// paced by the single port of the 4096x8 font memory and its registered read.
// The first row passes through the font read register and the output register.
// A new request is taken only while no character is being drawn; the last
// row may still sit in the output register when the next request is taken.
// When m_axis_tready is low the output register holds and the font reads
// pause, so no row is lost or repeated.
// Reset (aresetn low, synchronous) homes the cursor and empties the
// pipeline; the font memory is not cleared and must be loaded before use.
`default_nettype none
`include "text_console_glyph_renderer_defines.svh"

module text_console_glyph_renderer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // code[7:0], color[15:8], glyph_row[19:16], row_bits[27:20],
    // column[35:28], line[43:36], zero[47:44]
    input  wire logic [47:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pixel_address[18:0], pixel_mask[26:19], pixel_color[34:27], zero[39:35]
    output logic      [39:0] m_axis_tdata,
    // last_row
    output logic             m_axis_tlast
);

    tcgr_pkg::state_t state_reg, state_next;

    logic [tcgr_pkg::CNT_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [tcgr_pkg::ADDR_W-1:0] meta_addr_reg, meta_addr_next;
    logic                        meta_last_reg, meta_last_next;
    logic                        ram_vld_reg, ram_vld_next;
    logic [tcgr_pkg::CODE_W-1:0] code_reg, code_next;
    logic [7:0]                  color_reg, color_next;
    logic                        m_valid_reg, m_valid_next;
    logic [tcgr_pkg::ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [7:0]                  m_mask_reg, m_mask_next;
    logic [7:0]                  m_color_reg, m_color_next;
    logic                        m_last_reg, m_last_next;

    logic                          accept, start, adv, issue_row, rows_done;
    logic                          ram_we, ram_re;
    logic [tcgr_pkg::FONT_AW-1:0]  ram_addr;
    logic [7:0]                    ram_rdata;
    tcgr_pkg::op_t                 in_op;
    tcgr_pkg::cursor_req_t         cur_req;
    tcgr_pkg::cursor_stat_t        cur_stat;

    logic [tcgr_pkg::CODE_W-1:0] in_code;
    logic [7:0]                  in_color, in_bits, in_column, in_line;
    logic [tcgr_pkg::GROW_W-1:0] in_grow;

    assign in_op     = tcgr_pkg::op_t'(s_axis_tuser);
    assign in_code   = s_axis_tdata[7:0];
    assign in_color  = s_axis_tdata[15:8];
    assign in_grow   = s_axis_tdata[19:16];
    assign in_bits   = s_axis_tdata[27:20];
    assign in_column = s_axis_tdata[35:28];
    assign in_line   = s_axis_tdata[43:36];

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign start     = cur_stat.draw;
    assign adv       = !m_valid_reg || m_axis_tready;
    assign rows_done = (row_cnt_reg == tcgr_pkg::CNT_W'(tcgr_pkg::GLYPH_HEIGHT));

    assign cur_req.en     = accept;
    assign cur_req.op     = in_op;
    assign cur_req.code   = in_code;
    assign cur_req.column = in_column;
    assign cur_req.line   = in_line;

    tcgr_cursor u_cursor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cur_req),
        .stat    (cur_stat)
    );

    assign ram_we   = accept && (in_op == tcgr_pkg::OP_LOAD);
    assign ram_re   = start || issue_row;
    assign ram_addr = ram_we ? {in_code, in_grow} :
                      start  ? {in_code, tcgr_pkg::GROW_W'(0)} :
                               {code_reg, row_cnt_reg[tcgr_pkg::GROW_W-1:0]};

    tcgr_font_store u_font (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (in_bits),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcgr_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = tcgr_pkg::ST_DRAW;
                end
            end
            tcgr_pkg::ST_DRAW: begin
                if (adv && rows_done) begin
                    state_next = tcgr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcgr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        issue_row     = 1'b0;
        unique case (state_reg)
            tcgr_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            tcgr_pkg::ST_DRAW: begin
                issue_row = adv && !rows_done;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        row_cnt_next   = row_cnt_reg;
        meta_addr_next = meta_addr_reg;
        meta_last_next = meta_last_reg;
        ram_vld_next   = ram_vld_reg;
        code_next      = code_reg;
        color_next     = color_reg;
        m_valid_next   = m_valid_reg;
        m_addr_next    = m_addr_reg;
        m_mask_next    = m_mask_reg;
        m_color_next   = m_color_reg;
        m_last_next    = m_last_reg;

        if (adv) begin
            m_valid_next = ram_vld_reg;
            m_addr_next  = meta_addr_reg;
            m_mask_next  = ram_rdata;
            m_color_next = color_reg;
            m_last_next  = meta_last_reg;
            ram_vld_next = 1'b0;
        end

        if (start) begin
            row_cnt_next   = tcgr_pkg::CNT_W'(1);
            meta_addr_next = cur_stat.base_addr;
            meta_last_next = (tcgr_pkg::GLYPH_HEIGHT == 1);
            ram_vld_next   = 1'b1;
            code_next      = in_code;
            color_next     = in_color;
        end else if (issue_row) begin
            row_cnt_next   = row_cnt_reg + tcgr_pkg::CNT_W'(1);
            meta_addr_next = meta_addr_reg + tcgr_pkg::ADDR_W'(tcgr_pkg::LINE_PITCH);
            meta_last_next = (row_cnt_reg == tcgr_pkg::CNT_W'(tcgr_pkg::GLYPH_HEIGHT - 1));
            ram_vld_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tcgr_pkg::ST_IDLE;
            row_cnt_reg <= '0;
            ram_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            ram_vld_reg <= ram_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        meta_addr_reg <= meta_addr_next;
        meta_last_reg <= meta_last_next;
        code_reg      <= code_next;
        color_reg     <= color_next;
        m_addr_reg    <= m_addr_next;
        m_mask_reg    <= m_mask_next;
        m_color_reg   <= m_color_next;
        m_last_reg    <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, m_color_reg, m_mask_reg, m_addr_reg};
    assign m_axis_tlast  = m_last_reg;

    `TCGR_ASSERT_IMP(a_no_rw_clash, aclk, aresetn, ram_we, !ram_re,
        "font write and read in one cycle")
    `TCGR_ASSERT_IMP(a_ready_empty, aclk, aresetn, s_axis_tready, !ram_vld_reg,
        "request taken with a row pending")
    `TCGR_ASSERT_IMP(a_cnt_range, aclk, aresetn, 1'b1,
        row_cnt_reg <= tcgr_pkg::CNT_W'(tcgr_pkg::GLYPH_HEIGHT), "row count overrun")
    `TCGR_ASSERT_IMP(a_last_pending, aclk, aresetn,
        (state_reg == tcgr_pkg::ST_DRAW) && adv && rows_done,
        ram_vld_reg && meta_last_reg, "draw ends without final row")
    `TCGR_ASSERT_NXT(a_start_draw, aclk, aresetn, start,
        (state_reg == tcgr_pkg::ST_DRAW) && ram_vld_reg, "glyph start did not enter draw")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 360;
    localparam int HOLD_ITEMS   = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        tcgr_pkg::op_t op;
        logic [7:0]    code;
        logic [7:0]    color;
        logic [3:0]    glyph_row;
        logic [7:0]    row_bits;
        logic [7:0]    column;
        logic [7:0]    line;
    } console_req_t;

    typedef struct packed {
        logic [tcgr_pkg::ADDR_W-1:0] addr;
        logic [7:0]                  mask;
        logic [7:0]                  color;
        logic                        last;
    } row_write_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    text_console_glyph_renderer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2ns aclk = ~aclk;

    // console shadow state
    logic [tcgr_pkg::COL_W-1:0] cur_col = '0;
    logic [tcgr_pkg::ROW_W-1:0] cur_row = '0;
    logic [7:0]       font_bytes [4096];
    bit               font_set [4096];
    bit               glyph_ready [256];
    logic [7:0]       ready_codes [$];
    row_write_t       pending_rows [$];

    int  error_count     = 0;
    int  cycle_count     = 0;
    int  hold_off_cycles = 0;
    bit  idle_on         = 1'b1;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic console_req_t random_request(tcgr_pkg::op_t op);
        console_req_t r;
        r.op        = op;
        r.code      = 8'($urandom);
        r.color     = 8'($urandom);
        r.glyph_row = 4'($urandom);
        r.row_bits  = 8'($urandom);
        r.column    = 8'($urandom);
        r.line      = 8'($urandom);
        return r;
    endfunction

    task automatic bump_row();
        cur_row = cur_row + 1'b1;
        if (cur_row >= tcgr_pkg::ROWS || cur_row == '0) begin
            cur_row = tcgr_pkg::ROW_W'(tcgr_pkg::ROWS - 1);
        end
    endtask

    task automatic draw_glyph(logic [7:0] code, logic [7:0] color);
        row_write_t w;
        for (int i = 0; i < tcgr_pkg::GLYPH_HEIGHT; i++) begin
            w.addr  = tcgr_pkg::ADDR_W'(
                          (int'(cur_row) * tcgr_pkg::GLYPH_HEIGHT + i) * tcgr_pkg::LINE_PITCH
                          + int'(cur_col) * tcgr_pkg::CELL_WIDTH);
            w.mask  = font_bytes[{code, 4'(i)}];
            w.color = color;
            w.last  = (i == tcgr_pkg::GLYPH_HEIGHT - 1);
            pending_rows.push_back(w);
        end
        cur_col = cur_col + 1'b1;
        if (cur_col >= tcgr_pkg::COLUMNS || cur_col == '0) begin
            cur_col = '0;
            bump_row();
        end
    endtask

    task automatic store_font_row(console_req_t r);
        bit complete;
        font_bytes[{r.code, r.glyph_row}] = r.row_bits;
        font_set[{r.code, r.glyph_row}]   = 1'b1;
        if (!glyph_ready[r.code]) begin
            complete = 1'b1;
            for (int k = 0; k < 16; k++) begin
                if (!font_set[{r.code, 4'(k)}]) begin
                    complete = 1'b0;
                end
            end
            if (complete) begin
                glyph_ready[r.code] = 1'b1;
                ready_codes.push_back(r.code);
            end
        end
    endtask

    task automatic apply_request(console_req_t r);
        logic [7:0] tab_sum;
        case (r.op)
            tcgr_pkg::OP_PUT: begin
                if (r.code == tcgr_pkg::CODE_NL) begin
                    cur_col = '0;
                    bump_row();
                end else if (r.code == tcgr_pkg::CODE_CR) begin
                    cur_col = '0;
                end else if (r.code == tcgr_pkg::CODE_TAB) begin
                    tab_sum = {1'b0, cur_col} + 8'd8;
                    cur_col = tab_sum[tcgr_pkg::COL_W-1:0] & 7'h78;
                end else begin
                    draw_glyph(r.code, r.color);
                end
            end
            tcgr_pkg::OP_SET: begin
                cur_col = tcgr_pkg::COL_W'(int'(r.column) % (tcgr_pkg::COLUMNS + 1));
                cur_row = tcgr_pkg::ROW_W'(int'(r.line) % (tcgr_pkg::ROWS + 1));
            end
            tcgr_pkg::OP_LOAD: begin
                store_font_row(r);
            end
            tcgr_pkg::OP_HOME: begin
                cur_col = '0;
                cur_row = '0;
            end
        endcase
    endtask

    task automatic send_request(console_req_t r);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.op;
        s_axis_tdata  <= {4'b0, r.line, r.column, r.row_bits, r.glyph_row, r.color, r.code};
        do @(posedge aclk); while (!s_axis_tready);
        apply_request(r);
    endtask

    task automatic put_char(logic [7:0] code, logic [7:0] color);
        console_req_t r;
        r       = random_request(tcgr_pkg::OP_PUT);
        r.code  = code;
        r.color = color;
        send_request(r);
    endtask

    task automatic set_cursor(logic [7:0] column, logic [7:0] line);
        console_req_t r;
        r        = random_request(tcgr_pkg::OP_SET);
        r.column = column;
        r.line   = line;
        send_request(r);
    endtask

    task automatic load_glyph(logic [7:0] code);
        console_req_t r;
        int pick;
        for (int i = 0; i < 16; i++) begin
            r           = random_request(tcgr_pkg::OP_LOAD);
            r.code      = code;
            r.glyph_row = 4'(i);
            pick        = $urandom_range(0, 7);
            if (pick == 0) begin
                r.row_bits = 8'h00;
            end else if (pick == 1) begin
                r.row_bits = 8'hFF;
            end
            send_request(r);
        end
    endtask

    function automatic logic [7:0] any_ready_code();
        return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
    endfunction

    task automatic report_field(string name, logic [31:0] expv, logic [31:0] gotv);
        if (expv !== gotv) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, expv, gotv);
            error_count++;
        end
    endtask

    task automatic check_row();
        row_write_t w;
        if (pending_rows.size() == 0) begin
            $display("%0t: unexpected row write, expected none, actual %h last %b",
                     $realtime, m_axis_tdata, m_axis_tlast);
            error_count++;
        end else begin
            w = pending_rows.pop_front();
            report_field("pixel_address", 32'(w.addr),  32'(m_axis_tdata[18:0]));
            report_field("pixel_mask",    32'(w.mask),  32'(m_axis_tdata[26:19]));
            report_field("pixel_color",   32'(w.color), 32'(m_axis_tdata[34:27]));
            report_field("last_row",      32'(w.last),  32'(m_axis_tlast));
        end
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                check_row();
            end
            if (hold_off_cycles != 0) begin
                stall_left      = hold_off_cycles;
                hold_off_cycles = 0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                stall_left = idle_on ? $urandom_range(0, 6) : 0;
            end else if (stall_left != 0) begin
                stall_left--;
            end
            m_axis_tready <= (stall_left == 0);
        end
    end

    task automatic test_font_setup();
        load_glyph(8'h00);
        load_glyph(8'hFF);
    endtask

    task automatic test_directed();
        console_req_t r;
        send_request(random_request(tcgr_pkg::OP_HOME));
        put_char(8'h00, 8'h00);
        put_char(8'hFF, 8'hFF);
        set_cursor(8'hFF, 8'hFF);
        put_char(8'hFF, 8'h5A);
        set_cursor(8'(tcgr_pkg::COLUMNS), 8'(tcgr_pkg::ROWS));
        put_char(8'h00, 8'hA5);
        set_cursor(8'(tcgr_pkg::COLUMNS - 1), 8'(tcgr_pkg::ROWS - 1));
        put_char(8'hFF, 8'h0F);
        put_char(tcgr_pkg::CODE_NL, 8'($urandom));
        set_cursor(8'd40, 8'd2);
        put_char(tcgr_pkg::CODE_CR, 8'($urandom));
        put_char(8'h00, 8'hF0);
        put_char(tcgr_pkg::CODE_TAB, 8'($urandom));
        put_char(8'hFF, 8'h3C);
        set_cursor(8'(tcgr_pkg::COLUMNS), 8'd4);
        repeat (5) put_char(tcgr_pkg::CODE_TAB, 8'($urandom));
        put_char(8'h00, 8'hC3);
        put_char(tcgr_pkg::CODE_NL, 8'($urandom));
        set_cursor(8'h00, 8'h00);
        r = random_request(tcgr_pkg::OP_LOAD);
        r.code      = 8'hFF;
        r.glyph_row = 4'hF;
        r.row_bits  = 8'hFF;
        send_request(r);
    endtask

    task automatic test_hold_off();
        idle_on         = 1'b0;
        hold_off_cycles = HOLD_CYCLES;
        repeat (HOLD_ITEMS) put_char(any_ready_code(), 8'($urandom));
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        int sent;
        int next_toggle;
        int pick;
        logic [7:0] ctl;
        sent        = 0;
        next_toggle = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_toggle) begin
                idle_on     = ($urandom_range(0, 2) != 0);
                next_toggle = next_toggle + 50;
            end
            pick = $urandom_range(0, 99);
            if (pick < 4 && ready_codes.size() < 14) begin
                load_glyph(8'($urandom));
                sent = sent + 16;
            end else if (pick < 12) begin
                send_request(random_request(tcgr_pkg::OP_LOAD));
                sent++;
            end else if (pick < 16) begin
                set_cursor(8'($urandom), 8'($urandom));
                sent++;
            end else if (pick < 19) begin
                set_cursor(8'($urandom_range(tcgr_pkg::COLUMNS - 2, tcgr_pkg::COLUMNS)),
                           8'($urandom_range(tcgr_pkg::ROWS - 2, tcgr_pkg::ROWS)));
                sent++;
            end else if (pick < 22) begin
                send_request(random_request(tcgr_pkg::OP_HOME));
                sent++;
            end else if (pick < 32) begin
                case ($urandom_range(0, 2))
                    0:       ctl = tcgr_pkg::CODE_NL;
                    1:       ctl = tcgr_pkg::CODE_CR;
                    default: ctl = tcgr_pkg::CODE_TAB;
                endcase
                put_char(ctl, 8'($urandom));
                sent++;
            end else begin
                put_char(any_ready_code(), 8'($urandom));
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= tcgr_pkg::OP_HOME;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_font_setup();
        test_directed();
        test_hold_off();
        test_random();
        s_axis_tvalid <= 1'b0;

        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/tcgr_pkg.sv
src/tcgr_font_store.sv
src/tcgr_cursor.sv
src/text_console_glyph_renderer.sv
sim/tb_top.sv
